// ----- rtl/lsk_pkg.sv -----
// Shared types, constants and functions for the LFSR seed-to-key block.
package lsk_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 9;  // step count 0..510

  localparam logic [DataW-1:0] MaskReset = 32'h59DB7D73;
  localparam logic [7:0]       XorB      = 8'hA5;
  localparam logic [7:0]       XorC      = 8'h5A;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic load;
    logic shift;
  } lfsr_ctrl_t;

  // Step count from the selected seed byte and the mask fields.
  function automatic logic [CountW-1:0] step_count(input logic [DataW-1:0] seed,
                                                   input logic [DataW-1:0] mask);
    logic [1:0] sel;
    logic [7:0] sel_byte;
    logic [7:0] fa;
    logic [7:0] fb;
    logic [7:0] fc;
    sel = {mask[11], mask[21]};
    unique case (sel)
      2'd0: sel_byte = seed[31:24];
      2'd1: sel_byte = seed[23:16];
      2'd2: sel_byte = seed[15:8];
      2'd3: sel_byte = seed[7:0];
      default: sel_byte = seed[7:0];
    endcase
    fa = mask[9:2];
    fb = mask[30:23] ^ XorB;
    fc = mask[20:13] ^ XorC;
    return {1'b0, (sel_byte ^ fa) & fb} + {1'b0, fc};
  endfunction

  // One left shift, taps 30, 24, 12, 2 feeding bit 0.
  function automatic logic [DataW-1:0] lfsr_step(input logic [DataW-1:0] s);
    return {s[DataW-2:0], s[30] ^ s[24] ^ s[12] ^ s[2]};
  endfunction

  // Optional byte permutation, then the mask XOR.
  function automatic logic [DataW-1:0] finish_key(input logic [DataW-1:0] s,
                                                  input logic [DataW-1:0] mask);
    logic [DataW-1:0] w;
    w = mask[0] ? {s[15:8], s[31:24], s[7:0], s[23:16]} : s;
    return w ^ mask;
  endfunction

endpackage

// ----- rtl/lsk_lfsr.sv -----
// LFSR state register: loads the seed, then shifts once per enabled cycle.
module lsk_lfsr (
  input  logic                         clk_i,
  input  lsk_pkg::lfsr_ctrl_t          ctrl_i,
  input  logic [lsk_pkg::DataW-1:0]    seed_i,
  output logic [lsk_pkg::DataW-1:0]    state_o
);

  logic [lsk_pkg::DataW-1:0] s_d, s_q;

  always_comb begin
    s_d = s_q;
    if (ctrl_i.load) begin
      s_d = seed_i;
    end else if (ctrl_i.shift) begin
      s_d = lsk_pkg::lfsr_step(s_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign state_o = s_q;

endmodule

// ----- rtl/lsk_seq.sv -----
// Sequencer: takes a request, loads the step counter, runs the LFSR down to zero.
module lsk_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lsk_pkg::DataW-1:0]    seed_i,
  input  logic [lsk_pkg::DataW-1:0]    mask_i,
  output lsk_pkg::lfsr_ctrl_t          ctrl_o,
  output logic                         busy_o,
  output logic                         finish_o
);

  lsk_pkg::state_e            state_d, state_q;
  logic [lsk_pkg::CountW-1:0] cnt_d, cnt_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o      = '0;
    finish_o    = 1'b0;
    unique case (state_q)
      lsk_pkg::StIdle: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          cnt_d       = lsk_pkg::step_count(seed_i, mask_i);
          state_d     = lsk_pkg::StRun;
        end
      end
      lsk_pkg::StRun: begin
        if (cnt_q == '0) begin
          finish_o = 1'b1;
          state_d  = lsk_pkg::StIdle;
        end else begin
          ctrl_o.shift = 1'b1;
          cnt_d        = cnt_q - 1'b1;
        end
      end
      default: state_d = lsk_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsk_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != lsk_pkg::StIdle);

endmodule

// ----- rtl/lfsr_seed_key_derivation.sv -----
// Top level of the LFSR seed-to-key derivation block.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------
//  request   | start high while busy low     | seed_i[31:0]
//  result    | done_o strobe, one cycle      | key_o[31:0]
//  config    | cfg_valid_i and cfg_ready_o   | cfg_data_i[31:0] (key mask)
//
// On accept the seed is loaded into the LFSR and the step counter takes
// n = ((seed byte ^ a) & b) + c, which ranges 0..510. The single LFSR
// register then shifts once per cycle until the counter reaches zero.
// busy is high from the cycle after accept until done_o; a new request can
// be taken in the same cycle done_o is shown. The result cannot be stalled.
// Reset (rst_ni low, async) returns to idle and loads the mask reset value.
// cfg_ready_o is high whenever the block is idle.
module lfsr_seed_key_derivation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [lsk_pkg::DataW-1:0]    seed_i,
  output logic                         done_o,
  output logic [lsk_pkg::DataW-1:0]    key_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lsk_pkg::DataW-1:0]    cfg_data_i
);

  logic [lsk_pkg::DataW-1:0] mask_q;
  logic [lsk_pkg::DataW-1:0] lfsr_state;
  logic [lsk_pkg::DataW-1:0] key_d, key_q;
  logic                      done_q;
  logic                      finish;
  lsk_pkg::lfsr_ctrl_t       ctrl;

  // Mask register; only written while idle.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= lsk_pkg::MaskReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_q <= cfg_data_i;
    end
  end

  lsk_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .seed_i   (seed_i),
    .mask_i   (mask_q),
    .ctrl_o   (ctrl),
    .busy_o   (busy),
    .finish_o (finish)
  );

  lsk_lfsr u_lfsr (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .seed_i  (seed_i),
    .state_o (lfsr_state)
  );

  // Optional byte permutation (mask bit 0) and mask XOR on the final LFSR state, registered for output.
  assign key_d = lsk_pkg::finish_key(lfsr_state, mask_q);

  always_ff @(posedge clk_i) begin
    if (finish) begin
      key_q <= key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish;
    end
  end

  assign done_o = done_q;
  assign key_o  = key_q;

endmodule

// ----- rtl/lsk_chk.sv -----
// Port-level checker for the seed-to-key block, bound to the top level.
module lsk_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i,
  input logic cfg_ready_i
);

  // A request that is taken makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("busy not raised after accepted request");

  // The result strobe comes with the block idle again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i && $past(busy_i))
    else $error("done_o without a preceding busy period");

  // busy only drops when the result is shown.
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> done_i)
    else $error("busy dropped without a result");

  // One strobe per request: never two in a row.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe longer than one cycle");

  // Mask writes are only taken while idle.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !cfg_ready_i)
    else $error("config ready while busy");

endmodule

bind lfsr_seed_key_derivation lsk_chk u_lsk_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .done_i      (done_o),
  .cfg_ready_i (cfg_ready_o)
);
